@@ hdl/rm3014_pkg.sv @@
// Shared types and constants for the (30,14) Reed-Muller majority decoder.
// Holds the check-sum mask table and the stage payload structs.
// No dependencies.
package rm3014_pkg;

    localparam int CW_W         = 30;
    localparam int INFO_BITS    = 14;
    localparam int PAR_W        = 16;
    localparam int HALF_W       = 8;
    localparam int CHECKS       = 4;
    localparam int VOTE_W       = 3;
    localparam int VOTES_NEEDED = 3;

    typedef logic [INFO_BITS-1:0]             info_t;
    typedef logic [PAR_W-1:0]                 par_t;
    typedef logic [INFO_BITS-1:0][CHECKS-1:0] check_arr_t;

    // Stage 1 -> stage 2: partial check sums over parity bits p1..p8 and p9..p16.
    typedef struct packed {
        info_t      info;
        check_arr_t sum_lo;
        check_arr_t sum_hi;
    } half_t;

    // Stage 2 -> stage 3: complete check sums.
    typedef struct packed {
        info_t      info;
        check_arr_t sum;
    } chk_t;

    // Bit k-1 of a mask selects parity bit p_k (codeword bit 13+k).
    localparam par_t CHECK_MASK [INFO_BITS][CHECKS] = '{
        '{16'h0474, 16'h01B3, 16'h031E, 16'h06D9},
        '{16'h0519, 16'h0273, 16'h00DE, 16'h07B4},
        '{16'h0692, 16'h0355, 16'h01F8, 16'h043F},
        '{16'h39C0, 16'h3C07, 16'h3EAA, 16'h3B6D},
        '{16'h5C19, 16'h5EB4, 16'h5B73, 16'h59DE},
        '{16'h6B40, 16'h6C2A, 16'h6E87, 16'h69ED},
        '{16'h7434, 16'h7699, 16'h71F3, 16'h735E},
        '{16'hF952, 16'hFC95, 16'hFE38, 16'hFBFF},
        '{16'h9906, 16'h9CC1, 16'h9E6C, 16'h9BAB},
        '{16'hA885, 16'hAA28, 16'hAD42, 16'hAFEF},
        '{16'hB043, 16'hB584, 16'hB729, 16'hB2EE},
        '{16'hC922, 16'hCE48, 16'hCCE5, 16'hCB8F},
        '{16'hD690, 16'hD43D, 16'hD357, 16'hD1FA},
        '{16'hE04A, 16'hE720, 16'hE58D, 16'hE2E7}
    };

endpackage

@@ hdl/rm3014_half.sv @@
// Stage 1: splits the codeword and forms half check sums over each parity byte.
// Depends on rm3014_pkg.
module rm3014_half
    import rm3014_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [CW_W-1:0]    codeword,
    output logic               out_valid,
    input  logic               out_ready,
    output half_t              out_data
);

    logic  valid_reg;
    half_t data_reg;
    half_t data_next;
    par_t  par;

    assign par      = codeword[CW_W-1:INFO_BITS];
    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        data_next.info = codeword[INFO_BITS-1:0];
        for (int i = 0; i < INFO_BITS; i++)
        begin
            for (int j = 0; j < CHECKS; j++)
            begin
                data_next.sum_lo[i][j] = ^(par[HALF_W-1:0] & CHECK_MASK[i][j][HALF_W-1:0]);
                data_next.sum_hi[i][j] = ^(par[PAR_W-1:HALF_W]
                                           & CHECK_MASK[i][j][PAR_W-1:HALF_W]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ hdl/rm3014_check.sv @@
// Stage 2: merges the half sums into the four full check sums per info bit.
// Depends on rm3014_pkg.
module rm3014_check
    import rm3014_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  half_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output chk_t  out_data
);

    logic valid_reg;
    chk_t data_reg;
    chk_t data_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        data_next.info = in_data.info;
        data_next.sum  = in_data.sum_lo ^ in_data.sum_hi;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ hdl/rm3014_vote.sv @@
// Stage 3: 3-of-5 majority per info bit, result held in the output register.
// Depends on rm3014_pkg.
module rm3014_vote
    import rm3014_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  chk_t  in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output info_t out_bits
);

    logic  valid_reg;
    info_t bits_reg;
    info_t bits_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        logic [VOTE_W-1:0] cnt;
        for (int i = 0; i < INFO_BITS; i++)
        begin
            cnt = {{(VOTE_W-1){1'b0}}, in_data.info[i]};
            for (int j = 0; j < CHECKS; j++)
                cnt = cnt + {{(VOTE_W-1){1'b0}}, in_data.sum[i][j]};
            bits_next[i] = (cnt >= VOTE_W'(VOTES_NEEDED));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            bits_reg <= bits_next;
    end

    assign out_valid = valid_reg;
    assign out_bits  = bits_reg;

endmodule

@@ hdl/reed_muller_30_14_decoder.sv @@
// Majority-logic decoder for the shortened (30,14) Reed-Muller code.
// Three-stage pipeline: half check sums, full check sums, majority vote.
//
// Input channel: in_valid / in_ready carry one beat, a 30-bit codeword.
//   Bits 0..13 are the systematic info bits, bits 14..29 parity p1..p16.
// Output channel: out_valid / out_ready carry one beat per codeword,
//   decoded_bits, bit i = 3-of-5 majority of info bit i and its four
//   parity check sums.
// An accepted codeword moves through the half, check and vote registers
//   in turn; out_valid rises once it sits in the vote register.
// Throughput: one codeword per cycle; each stage is a register with its
//   own valid bit, so a new beat is taken every cycle while the pipe flows.
// Stall: each stage's ready is "stage empty or next stage taking", so when
//   the receiver holds out_ready low the pipe fills up to three beats and
//   then in_ready drops. Nothing is dropped or repeated; payload registers
//   only load on a completed handshake.
// Reset: rst_n (async, active low) clears all stage valid bits; the pipe
//   is empty and ready right after reset. Payload registers are not reset.
// Depends on rm3014_pkg, rm3014_half, rm3014_check, rm3014_vote.
module reed_muller_30_14_decoder
    import rm3014_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CW_W-1:0]      codeword,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [INFO_BITS-1:0] decoded_bits
);

    // stage 1 -> stage 2
    logic  s1_valid;
    logic  s1_ready;
    half_t s1_data;

    // stage 2 -> stage 3
    logic  s2_valid;
    logic  s2_ready;
    chk_t  s2_data;

    // Half sums: each check sum split into an XOR over p1..p8 and one over p9..p16.
    rm3014_half u_half (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .codeword  (codeword),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    // Full check sums.
    rm3014_check u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    // Majority vote; its register is the output register.
    rm3014_vote u_vote (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_bits  (decoded_bits)
    );

endmodule

@@ test/rm3014_decode_checker.sv @@
// Scoreboard for the (30,14) Reed-Muller majority decoder: predicts decoded_bits
// for each codeword beat taken in and compares the output beats in order.
// Depends on rm3014_pkg for CW_W and INFO_BITS only.
module rm3014_decode_checker
    import rm3014_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [CW_W-1:0]      codeword,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [INFO_BITS-1:0] decoded_bits,
    output int                   mismatches,
    output int                   pending
);

    localparam int NUM_SUMS   = 4;
    localparam int PARITY_LSB = 14;
    localparam int MAJORITY   = 3;

    // Check-sum parity sets per info bit; bit k-1 picks p_k (codeword bit 13+k).
    localparam logic [15:0] PARITY_SETS [INFO_BITS][NUM_SUMS] = '{
        '{16'h0474, 16'h01B3, 16'h031E, 16'h06D9},
        '{16'h0519, 16'h0273, 16'h00DE, 16'h07B4},
        '{16'h0692, 16'h0355, 16'h01F8, 16'h043F},
        '{16'h39C0, 16'h3C07, 16'h3EAA, 16'h3B6D},
        '{16'h5C19, 16'h5EB4, 16'h5B73, 16'h59DE},
        '{16'h6B40, 16'h6C2A, 16'h6E87, 16'h69ED},
        '{16'h7434, 16'h7699, 16'h71F3, 16'h735E},
        '{16'hF952, 16'hFC95, 16'hFE38, 16'hFBFF},
        '{16'h9906, 16'h9CC1, 16'h9E6C, 16'h9BAB},
        '{16'hA885, 16'hAA28, 16'hAD42, 16'hAFEF},
        '{16'hB043, 16'hB584, 16'hB729, 16'hB2EE},
        '{16'hC922, 16'hCE48, 16'hCCE5, 16'hCB8F},
        '{16'hD690, 16'hD43D, 16'hD357, 16'hD1FA},
        '{16'hE04A, 16'hE720, 16'hE58D, 16'hE2E7}
    };

    logic [INFO_BITS-1:0] expected_decodes [$];
    int                   out_beats;

    // 3-of-5 vote: the info bit itself plus four parity check sums.
    function automatic logic [INFO_BITS-1:0] majority_decode(input logic [CW_W-1:0] cw);
        logic [15:0]          par;
        logic [INFO_BITS-1:0] bits;
        int                   votes;
        par  = cw[CW_W-1:PARITY_LSB];
        bits = '0;
        for (int i = 0; i < INFO_BITS; i++)
        begin
            votes = int'(cw[i]);
            for (int j = 0; j < NUM_SUMS; j++)
                votes += int'(^(par & PARITY_SETS[i][j]));
            bits[i] = (votes >= MAJORITY);
        end
        return bits;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] decode check, output beat %0d: %s", $time, out_beats, what);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : watch_beats
        logic [INFO_BITS-1:0] want;
        if (!rst_n)
        begin
            mismatches = 0;
            out_beats  = 0;
            expected_decodes.delete();
            pending <= 0;
        end
        else
        begin
            // Output side first, so a same-edge input beat never matches itself.
            if (out_valid && out_ready)
            begin
                if (expected_decodes.size() == 0)
                    report_mismatch($sformatf("unexpected beat, bits %h", decoded_bits));
                else
                begin
                    want = expected_decodes.pop_front();
                    if (decoded_bits !== want)
                        report_mismatch($sformatf("decoded_bits %h, want %h",
                                                  decoded_bits, want));
                end
                out_beats++;
            end
            if (in_valid && in_ready)
                expected_decodes.insert(expected_decodes.size(), majority_decode(codeword));
            pending <= expected_decodes.size();
        end
    end

endmodule

@@ test/testbench.sv @@
// Top of the (30,14) Reed-Muller decoder testbench: clock, reset, codeword
// stimulus, random output back-pressure and the final verdict.
// Depends on rm3014_pkg, reed_muller_30_14_decoder and rm3014_decode_checker.
module testbench
    import rm3014_pkg::*;
();

    localparam int NUM_PHASES   = 3;
    localparam int PHASE_BEATS  = 583;
    localparam int PARITY_LSB   = 14;
    localparam int PARITY_COUNT = 16;
    localparam int TAIL_CYCLES  = 8;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic [CW_W-1:0]      codeword  = '0;
    logic                 out_ready = 1'b0;
    logic                 in_ready;
    logic                 out_valid;
    logic [INFO_BITS-1:0] decoded_bits;
    int                   mismatches;
    int                   pending;

    // Chance in percent that the sender inserts an idle cycle before a beat,
    // and that the receiver holds out_ready low in a given cycle.
    int src_idle_pct  = 30;
    int sink_idle_pct = 52;

    always #1 clk = ~clk;

    reed_muller_30_14_decoder u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .codeword     (codeword),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .decoded_bits (decoded_bits)
    );

    rm3014_decode_checker u_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .codeword     (codeword),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .decoded_bits (decoded_bits),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    // Receiver: a fresh coin each cycle, so stalls hit every pipe fill level.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // One codeword beat. Valid stays up, payload held, until in_ready is seen
    // at an edge. An idle gap lowers valid only in cycles before the next
    // beat, never in the same step that raises it again.
    task automatic send_codeword(input logic [CW_W-1:0] cw);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        codeword <= cw;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Half plain random words; the rest sparse or dense patterns, which push
    // most check sums the same way and land near the vote threshold.
    function automatic logic [CW_W-1:0] random_codeword();
        logic [CW_W-1:0] cw;
        int              flips;
        flips = $urandom_range(1, 3);
        case ($urandom_range(3))
            0, 1:
                cw = CW_W'($urandom());
            2:
            begin
                cw = '0;
                repeat (flips) cw[$urandom_range(CW_W-1)] = 1'b1;
            end
            default:
            begin
                cw = '1;
                repeat (flips) cw[$urandom_range(CW_W-1)] = 1'b0;
            end
        endcase
        return cw;
    endfunction

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: all zeros, all ones, info only, parity only, alternating
        // bits, then each parity bit alone (touches every check sum on its own).
        send_codeword('0);
        send_codeword('1);
        send_codeword({{PARITY_COUNT{1'b0}}, {INFO_BITS{1'b1}}});
        send_codeword({{PARITY_COUNT{1'b1}}, {INFO_BITS{1'b0}}});
        send_codeword(CW_W'(32'h1555_5555));
        send_codeword(CW_W'(32'h2AAA_AAAA));
        for (int k = 0; k < PARITY_COUNT; k++)
            send_codeword(CW_W'(1) << (PARITY_LSB + k));

        // Random: heavy receiver stalls, then heavy sender gaps, then full rate.
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct  = 30;
                    sink_idle_pct = 52;
                end
                1:
                begin
                    src_idle_pct  = 52;
                    sink_idle_pct = 30;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            repeat (PHASE_BEATS) send_codeword(random_codeword());
        end
        in_valid <= 1'b0;

        // pending trails the edge by one update, so step once before reading it.
        do
            @(posedge clk);
        while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("reed_muller_30_14_decoder: match");
        else
            $display("reed_muller_30_14_decoder: mismatch");
        $finish;
    end

    // Watchdog: a correct run takes well under a tenth of this.
    initial
    begin
        #400000;
        $display("reed_muller_30_14_decoder: mismatch");
        $finish;
    end

endmodule
